[sv/rectangle_fill_outline_raster_unit_macros.svh]
// Assertion shorthands for the raster unit checks.
`ifndef RECTANGLE_FILL_OUTLINE_RASTER_UNIT_MACROS_SVH
`define RECTANGLE_FILL_OUTLINE_RASTER_UNIT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define RFO_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("raster unit check failed");

// Next-cycle implication, idle during reset.
`define RFO_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("raster unit check failed");

`endif

[sv/rfo_pkg.sv]
package rfo_pkg;

  localparam int MAX_GRID = 128;

  localparam int OP_W    = 2;
  localparam int COORD_W = 8;
  localparam int LEN_W   = 8;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 8;

  localparam logic [CFG_W-1:0]   GRID_RESET = 8'd128;
  localparam logic [COLOR_W-1:0] BG_CODE    = 8'd46;

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
  localparam logic [OP_W-1:0] OP_OUTLINE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam int SIDE_W = $clog2(MAX_GRID + 1);
  localparam int IDX_W  = $clog2(MAX_GRID);
  localparam int DEPTH  = MAX_GRID * MAX_GRID;
  localparam int ADDR_W = $clog2(DEPTH);
  // wide enough for x + w - 1 and for the active side
  localparam int SPAN_W = ((SIDE_W > COORD_W + 1) ? SIDE_W : COORD_W + 1) + 1;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic valid;
    logic in_grid;
  } rd_evt_t;

  // 1-based row and column to a row-major store address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [SPAN_W-1:0] row,
                                                  input logic [SPAN_W-1:0] col);
    logic [SPAN_W-1:0] r0;
    logic [SPAN_W-1:0] c0;
    r0 = row - SPAN_W'(1);
    c0 = col - SPAN_W'(1);
    return ADDR_W'(r0[IDX_W-1:0]) * ADDR_W'(MAX_GRID) + ADDR_W'(c0[IDX_W-1:0]);
  endfunction

endpackage

[sv/rfo_req_if.sv]
interface rfo_req_if;
  import rfo_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    req_type;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [LEN_W-1:0]   rect_width;
  logic [LEN_W-1:0]   rect_height;
  logic [COLOR_W-1:0] paint_color;

  modport source (output valid, req_type, pos_x, pos_y, rect_width, rect_height,
                  paint_color, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, rect_width, rect_height,
                  paint_color, output ready);
endinterface

[sv/rfo_rsp_if.sv]
interface rfo_rsp_if;
  import rfo_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] cell_color;
  logic               in_grid;

  modport source (output valid, cell_color, in_grid, input ready);
  modport sink   (input valid, cell_color, in_grid, output ready);
endinterface

[sv/rfo_frame_ram.sv]
module rfo_frame_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

[sv/rfo_seq.sv]
module rfo_seq (
  input  logic                      clk,
  input  logic                      rst,
  rfo_req_if.sink                   req,
  input  logic [rfo_pkg::SIDE_W-1:0] side,
  input  logic                      out_free,
  output rfo_pkg::mem_cmd_t         cmd,
  output rfo_pkg::rd_evt_t          rd
);
  import rfo_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RDONE = 3'd5;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [ADDR_W-1:0]  init_addr;
  logic [SIDE_W-1:0]  walk_row;
  logic [SIDE_W-1:0]  walk_col;

  // captured transaction
  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [LEN_W-1:0]   w;
  logic [LEN_W-1:0]   h;
  logic [COLOR_W-1:0] color;

  // walk bounds
  logic [SPAN_W-1:0]  x_end;
  logic [SPAN_W-1:0]  y_end;
  logic [SIDE_W-1:0]  r_hi;
  logic [SIDE_W-1:0]  c_lo;
  logic [SIDE_W-1:0]  c_hi;
  logic               border_only;
  logic               rd_hit;

  logic [SPAN_W-1:0]  xs, ys, gs;
  logic [SPAN_W-1:0]  x_end_c, y_end_c;
  logic [SPAN_W-1:0]  p_r_lo, p_r_hi, p_c_lo, p_c_hi;
  logic               p_empty;
  logic [SPAN_W-1:0]  wr_s, wc_s;
  logic               on_border;
  logic               last_col, last_row;
  logic               rd_inside;
  logic               accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign xs      = SPAN_W'(x);
  assign ys      = SPAN_W'(y);
  assign gs      = SPAN_W'(side);
  assign x_end_c = xs + SPAN_W'(w) - SPAN_W'(1);
  assign y_end_c = ys + SPAN_W'(h) - SPAN_W'(1);

  // clip the rectangle to the active square
  always_comb begin
    if (op == OP_CLEAR) begin
      p_r_lo  = SPAN_W'(1);
      p_c_lo  = SPAN_W'(1);
      p_r_hi  = gs;
      p_c_hi  = gs;
      p_empty = (side == '0);
    end else begin
      p_r_lo  = (ys == '0) ? SPAN_W'(1) : ys;
      p_c_lo  = (xs == '0) ? SPAN_W'(1) : xs;
      p_r_hi  = (y_end_c > gs) ? gs : y_end_c;
      p_c_hi  = (x_end_c > gs) ? gs : x_end_c;
      p_empty = (side == '0) || (w == '0) || (h == '0) ||
                (p_r_lo > p_r_hi) || (p_c_lo > p_c_hi);
    end
  end

  assign wr_s      = SPAN_W'(walk_row);
  assign wc_s      = SPAN_W'(walk_col);
  assign on_border = (wr_s == ys) || (wr_s == y_end) || (wc_s == xs) || (wc_s == x_end);
  assign last_col  = (walk_col == c_hi);
  assign last_row  = (walk_row == r_hi);
  assign rd_inside = (xs != '0) && (xs <= gs) && (ys != '0) && (ys <= gs);

  always_comb begin
    cmd.we    = 1'b0;
    cmd.re    = 1'b0;
    cmd.addr  = init_addr;
    cmd.wdata = BG_CODE;
    case (state)
      S_INIT: begin
        cmd.we = 1'b1;
      end
      S_WALK: begin
        cmd.we    = !border_only || on_border;
        cmd.addr  = cell_addr(wr_s, wc_s);
        cmd.wdata = color;
      end
      S_READ: begin
        cmd.re   = rd_inside;
        cmd.addr = cell_addr(ys, xs);
      end
      default: begin
        cmd.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  if (init_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = (req.req_type == OP_READ) ? S_READ : S_PREP;
      S_PREP:  state_next = p_empty ? S_IDLE : S_WALK;
      S_WALK:  if (last_col && last_row) state_next = S_IDLE;
      S_READ:  state_next = S_RDONE;
      S_RDONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign rd.valid   = (state == S_RDONE) && out_free;
  assign rd.in_grid = rd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      walk_row  <= '0;
      walk_col  <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_addr <= init_addr + ADDR_W'(1);
      end
      if (state == S_PREP && !p_empty) begin
        walk_row <= SIDE_W'(p_r_lo);
        walk_col <= SIDE_W'(p_c_lo);
      end
      if (state == S_WALK) begin
        if (last_col) begin
          walk_col <= c_lo;
          if (!last_row) begin
            walk_row <= walk_row + SIDE_W'(1);
          end
        end else begin
          walk_col <= walk_col + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.req_type;
      x     <= req.pos_x;
      y     <= req.pos_y;
      w     <= req.rect_width;
      h     <= req.rect_height;
      color <= req.paint_color;
    end
    if (state == S_PREP) begin
      x_end       <= x_end_c;
      y_end       <= y_end_c;
      r_hi        <= SIDE_W'(p_r_hi);
      c_lo        <= SIDE_W'(p_c_lo);
      c_hi        <= SIDE_W'(p_c_hi);
      border_only <= (op == OP_OUTLINE);
      if (op == OP_CLEAR) begin
        color <= BG_CODE;
      end
    end
    if (state == S_READ) begin
      rd_hit <= rd_inside;
    end
  end
endmodule

[sv/rectangle_fill_outline_raster_unit.sv]
// Rectangle fill and outline raster unit. A MAX_GRID x MAX_GRID store of
// 8-bit colour codes sits in one single-port synchronous RAM; the side
// register (clamped to MAX_GRID) selects the active square of rows and
// columns 1..G, row 1 at the bottom. Requests are clear, fill, outline and
// read; painted cells outside the active square are clipped, and a read
// outside it returns in_grid 0 with cell_color 0. One transaction is worked
// at a time, and the RAM write port sets the pace at one cell per cycle: a
// read goes through the read and done states, waiting in the latter for a
// free output register, which then takes its result; a fill or outline
// passes a prepare state and then walks each cell of the clipped rectangle
// (up to 16384 with a 128 grid), and a clear walks all G*G cells. After reset
// the unit sweeps the whole store to the background code '.' at one cell a
// cycle and holds ready low until the sweep ends; writes to the side register
// are taken during the sweep. A finished read result waits in the output
// register, so the next request can be accepted while the result is still
// to be taken. Write the side register only while the unit is idle.
module rectangle_fill_outline_raster_unit (
  input  logic                     clk,
  input  logic                     rst,
  rfo_req_if.sink                  req,
  rfo_rsp_if.source                rsp,
  input  logic                     cfg_we,
  input  logic [rfo_pkg::CFG_W-1:0] cfg_wdata
);
  import rfo_pkg::*;

  logic [CFG_W-1:0]   side_cfg;
  logic [SIDE_W-1:0]  side;
  logic               out_free;
  mem_cmd_t           cmd;
  rd_evt_t            rd;
  logic [COLOR_W-1:0] ram_rdata;

  // clamp the active square to the store size
  assign side = (int'(side_cfg) > MAX_GRID) ? SIDE_W'(MAX_GRID) : SIDE_W'(side_cfg);

  // the result slot is free when empty or being drained this cycle
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= GRID_RESET;
    end else if (cfg_we) begin
      side_cfg <= cfg_wdata;
    end
  end

  rfo_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .side     (side),
    .out_free (out_free),
    .cmd      (cmd),
    .rd       (rd)
  );

  rfo_frame_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .re    (cmd.re),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (ram_rdata)
  );

  // output register: load a finished read, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rd.valid) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.valid) begin
      rsp.cell_color <= rd.in_grid ? ram_rdata : '0;
      rsp.in_grid    <= rd.in_grid;
    end
  end
endmodule

[sv/rfo_checker.sv]
`include "rectangle_fill_outline_raster_unit_macros.svh"

module rfo_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [rfo_pkg::COLOR_W-1:0] cell_color,
  input logic                       in_grid
);
  import rfo_pkg::*;

  // the store sweep after reset keeps requests out
  `RFO_ASSERT_IMP(a_sweep_after_reset, clk, rst, $fell(rst), !req_ready)
  // one transaction at a time
  `RFO_ASSERT_NXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  // an out-of-grid read carries no colour
  `RFO_ASSERT_IMP(a_clip_colour, clk, rst, rsp_valid && !in_grid, cell_color == '0)
  // a stalled result stays
  `RFO_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `RFO_ASSERT_NXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready,
                  $stable(cell_color) && $stable(in_grid))
endmodule

bind rectangle_fill_outline_raster_unit rfo_checker u_rfo_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cell_color (rsp.cell_color),
  .in_grid    (rsp.in_grid)
);
